// File: rtl/pej_pkg.sv
// Shared types and constants for the partner event journal.
package pej_pkg;

  localparam int PARTNER_SLOTS = 8;
  localparam int LOG_DEPTH = 32;
  localparam int SLOT_W = $clog2(PARTNER_SLOTS);
  localparam int PTR_W = $clog2(LOG_DEPTH);
  localparam int PID_W = 16;
  localparam int EVENT_W = 8;
  localparam int STAMP_W = 16;
  localparam int ENTRY_W = EVENT_W + STAMP_W;
  localparam int STATUS_W = 2;

  typedef enum logic [1:0] {
    CMD_LOG    = 2'd0,
    CMD_SELECT = 2'd1,
    CMD_PLOG   = 2'd2,
    CMD_PURGE  = 2'd3
  } cmd_t;

  typedef enum logic [STATUS_W-1:0] {
    ST_OK         = 2'd0,
    ST_NO_PARTNER = 2'd1,
    ST_ZERO_ID    = 2'd2
  } status_t;

  typedef struct packed {
    logic capture;
    logic execute;
  } ctrl_cmd_t;

endpackage

// File: rtl/pej_ctrl.sv
// Controller state machine: request handshakes and sequencing of the datapath.
module pej_ctrl (
  input  logic             clk,
  input  logic             rst,
  input  logic             in_valid,
  output logic             in_ready,
  output logic             out_valid,
  input  logic             out_ready,
  output pej_pkg::ctrl_cmd_t ctrl
);
  import pej_pkg::*;

  typedef enum logic [1:0] {
    S_IDLE = 2'b01,
    S_EXEC = 2'b10
  } state_t;

  state_t state;
  state_t state_next;
  logic out_valid_next;
  logic out_free;

  assign in_ready = (state == S_IDLE) && !rst;
  assign out_free = !out_valid || out_ready;
  assign ctrl.capture = in_valid && in_ready;
  assign ctrl.execute = (state == S_EXEC) && out_free;

  always_comb begin
    state_next = state;
    case (state)
      S_IDLE: begin
        if (ctrl.capture) begin
          state_next = S_EXEC;
        end
      end
      S_EXEC: begin
        if (out_free) begin
          state_next = S_IDLE;
        end
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

  always_comb begin
    out_valid_next = out_valid;
    if (ctrl.execute) begin
      out_valid_next = 1'b1;
    end else if (out_ready) begin
      out_valid_next = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      out_valid <= 1'b0;
    end else begin
      state <= state_next;
      out_valid <= out_valid_next;
    end
  end

endmodule

// File: rtl/pej_datapath.sv
// Datapath: request register, partner table, write pointers, ring logs and result register.
module pej_datapath (
  input  logic                         clk,
  input  logic                         rst,
  input  pej_pkg::ctrl_cmd_t           ctrl,
  input  logic [1:0]                   cmd,
  input  logic [pej_pkg::PID_W-1:0]    partner_id,
  input  logic [pej_pkg::EVENT_W-1:0]  event_code,
  input  logic [pej_pkg::STAMP_W-1:0]  time_stamp,
  output logic [pej_pkg::STATUS_W-1:0] status,
  output logic [pej_pkg::SLOT_W-1:0]   slot_used,
  output logic [pej_pkg::PTR_W-1:0]    entry_written,
  output logic                         new_partner,
  output logic                         evicted
);
  import pej_pkg::*;

  cmd_t               cmd_q;
  logic [PID_W-1:0]   pid_q;
  logic [ENTRY_W-1:0] entry_q;

  logic [PID_W-1:0]  slot_owner [PARTNER_SLOTS];
  logic [PTR_W-1:0]  slot_wp [PARTNER_SLOTS];
  logic [PTR_W-1:0]  global_wp;
  logic [SLOT_W-1:0] current_slot;
  logic              current_valid;

  logic [ENTRY_W-1:0] global_mem [LOG_DEPTH];
  logic [ENTRY_W-1:0] partner_mem [PARTNER_SLOTS*LOG_DEPTH];

  logic              hit;
  logic [SLOT_W-1:0] hit_slot;
  logic              found_free;
  logic [SLOT_W-1:0] free_slot;
  logic [SLOT_W-1:0] alloc_slot;
  logic [PTR_W-1:0]  cur_wp;

  logic [STATUS_W-1:0] status_next;
  logic [SLOT_W-1:0]   slot_next;
  logic [PTR_W-1:0]    entry_next;
  logic                new_next;
  logic                evict_next;

  always_ff @(posedge clk) begin
    if (ctrl.capture) begin
      cmd_q <= cmd_t'(cmd);
      pid_q <= partner_id;
      entry_q <= {event_code, time_stamp};
    end
  end

  always_comb begin
    hit = 1'b0;
    hit_slot = '0;
    found_free = 1'b0;
    free_slot = '0;
    for (int i = PARTNER_SLOTS - 1; i >= 0; i--) begin
      if (slot_owner[i] == pid_q) begin
        hit = 1'b1;
        hit_slot = SLOT_W'(i);
      end
      if (slot_owner[i] == '0) begin
        found_free = 1'b1;
        free_slot = SLOT_W'(i);
      end
    end
  end

  assign alloc_slot = found_free ? free_slot : '0;
  assign cur_wp = slot_wp[current_slot];

  always_comb begin
    status_next = ST_OK;
    slot_next = '0;
    entry_next = '0;
    new_next = 1'b0;
    evict_next = 1'b0;
    case (cmd_q)
      CMD_LOG: begin
        entry_next = global_wp;
      end
      CMD_SELECT: begin
        if (pid_q == '0) begin
          status_next = ST_ZERO_ID;
        end else if (hit) begin
          slot_next = hit_slot;
        end else begin
          slot_next = alloc_slot;
          new_next = 1'b1;
          evict_next = !found_free;
        end
      end
      CMD_PLOG: begin
        if (!current_valid) begin
          status_next = ST_NO_PARTNER;
        end else begin
          slot_next = current_slot;
          entry_next = cur_wp;
        end
      end
      default: begin
        status_next = ST_OK;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      for (int i = 0; i < PARTNER_SLOTS; i++) begin
        slot_owner[i] <= '0;
        slot_wp[i] <= '0;
      end
      global_wp <= '0;
      current_slot <= '0;
      current_valid <= 1'b0;
    end else if (ctrl.execute) begin
      case (cmd_q)
        CMD_LOG: begin
          global_wp <= global_wp + 1'b1;
        end
        CMD_SELECT: begin
          if (pid_q != '0) begin
            current_valid <= 1'b1;
            if (hit) begin
              current_slot <= hit_slot;
            end else begin
              current_slot <= alloc_slot;
              slot_owner[alloc_slot] <= pid_q;
            end
          end
        end
        CMD_PLOG: begin
          if (current_valid) begin
            slot_wp[current_slot] <= cur_wp + 1'b1;
          end
        end
        default: begin
          for (int i = 0; i < PARTNER_SLOTS; i++) begin
            slot_owner[i] <= '0;
            slot_wp[i] <= '0;
          end
          global_wp <= '0;
          current_slot <= '0;
          current_valid <= 1'b0;
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (ctrl.execute && (cmd_q == CMD_LOG)) begin
      global_mem[global_wp] <= entry_q;
    end
    if (ctrl.execute && (cmd_q == CMD_PLOG) && current_valid) begin
      partner_mem[{current_slot, cur_wp}] <= entry_q;
    end
  end

  always_ff @(posedge clk) begin
    if (ctrl.execute) begin
      status <= status_next;
      slot_used <= slot_next;
      entry_written <= entry_next;
      new_partner <= new_next;
      evicted <= evict_next;
    end
  end

endmodule

// File: rtl/partner_event_journal_top.sv
// Top level of the partner event journal: controller and datapath.
//
// Each request carries a command, a partner id, an event code and a timestamp and
// yields exactly one result. A request is registered when accepted and executed as
// soon as the output is free; then the partner table lookup (a parallel compare
// over all slots), the pointer updates and the ring memory write happen together
// and the result register is loaded. A new request is accepted while the previous
// result still waits on the output, but not while a request waits for execution.
// The ring memories have no reset and are never read back; purge clears the
// partner table and all pointers at once.
module partner_event_journal_top (
  input  logic                         clk,
  input  logic                         rst,
  input  logic                         in_valid,
  output logic                         in_ready,
  input  logic [1:0]                   cmd,
  input  logic [pej_pkg::PID_W-1:0]    partner_id,
  input  logic [pej_pkg::EVENT_W-1:0]  event_code,
  input  logic [pej_pkg::STAMP_W-1:0]  time_stamp,
  output logic                         out_valid,
  input  logic                         out_ready,
  output logic [pej_pkg::STATUS_W-1:0] status,
  output logic [pej_pkg::SLOT_W-1:0]   slot_used,
  output logic [pej_pkg::PTR_W-1:0]    entry_written,
  output logic                         new_partner,
  output logic                         evicted
);
  import pej_pkg::*;

  ctrl_cmd_t ctrl;

  pej_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .ctrl      (ctrl)
  );

  pej_datapath u_datapath (
    .clk           (clk),
    .rst           (rst),
    .ctrl          (ctrl),
    .cmd           (cmd),
    .partner_id    (partner_id),
    .event_code    (event_code),
    .time_stamp    (time_stamp),
    .status        (status),
    .slot_used     (slot_used),
    .entry_written (entry_written),
    .new_partner   (new_partner),
    .evicted       (evicted)
  );

endmodule

// File: bench/partner_event_journal_top_tb.sv
// Self-checking testbench for the partner event journal with an in-bench result predictor.
`timescale 1ns / 100ps

module partner_event_journal_top_tb;
  import pej_pkg::*;

  typedef struct packed {
    status_t            st;
    logic [SLOT_W-1:0]  slot;
    logic [PTR_W-1:0]   entry;
    logic               fresh;
    logic               evict;
  } journal_result_t;

  logic                clk = 1'b0;
  logic                rst;
  logic                in_valid;
  logic                in_ready;
  logic [1:0]          cmd;
  logic [PID_W-1:0]    partner_id;
  logic [EVENT_W-1:0]  event_code;
  logic [STAMP_W-1:0]  time_stamp;
  logic                out_valid;
  logic                out_ready;
  logic [STATUS_W-1:0] status;
  logic [SLOT_W-1:0]   slot_used;
  logic [PTR_W-1:0]    entry_written;
  logic                new_partner;
  logic                evicted;

  logic [PID_W-1:0] owner_of_slot [PARTNER_SLOTS];
  logic [PTR_W-1:0] slot_ptr [PARTNER_SLOTS];
  logic [PTR_W-1:0] global_ptr;
  logic [SLOT_W-1:0] active_slot;
  logic             active_valid;

  journal_result_t  pending_results [$];
  logic [PID_W-1:0] id_pool [16];
  int               mismatch_count = 0;
  int               result_count = 0;
  bit               gaps_on = 1'b0;
  bit               stalls_on = 1'b0;

  partner_event_journal_top uut (
    .clk(clk), .rst(rst),
    .in_valid(in_valid), .in_ready(in_ready),
    .cmd(cmd), .partner_id(partner_id), .event_code(event_code), .time_stamp(time_stamp),
    .out_valid(out_valid), .out_ready(out_ready),
    .status(status), .slot_used(slot_used), .entry_written(entry_written),
    .new_partner(new_partner), .evicted(evicted)
  );

  always #5 clk = ~clk;

  function automatic void clear_journal();
    for (int i = 0; i < PARTNER_SLOTS; i++) begin
      owner_of_slot[i] = '0;
      slot_ptr[i] = '0;
    end
    global_ptr = '0;
    active_slot = '0;
    active_valid = 1'b0;
  endfunction

  function automatic journal_result_t predict_journal(cmd_t c, logic [PID_W-1:0] pid);
    journal_result_t r;
    bit hit;
    bit have_free;
    int hit_slot;
    int free_slot;
    int target;
    r = '{st: ST_OK, slot: '0, entry: '0, fresh: 1'b0, evict: 1'b0};
    hit = 1'b0;
    have_free = 1'b0;
    hit_slot = 0;
    free_slot = 0;
    case (c)
      CMD_LOG: begin
        r.entry = global_ptr;
        global_ptr = global_ptr + 1'b1;
      end
      CMD_SELECT: begin
        if (pid == '0) begin
          r.st = ST_ZERO_ID;
        end else begin
          for (int i = 0; i < PARTNER_SLOTS; i++) begin
            if (!hit && owner_of_slot[i] == pid) begin
              hit = 1'b1;
              hit_slot = i;
            end
            if (!have_free && owner_of_slot[i] == '0) begin
              have_free = 1'b1;
              free_slot = i;
            end
          end
          if (hit) begin
            target = hit_slot;
          end else begin
            target = have_free ? free_slot : 0;
            owner_of_slot[target] = pid;
            r.fresh = 1'b1;
            r.evict = !have_free;
          end
          active_slot = target[SLOT_W-1:0];
          active_valid = 1'b1;
          r.slot = target[SLOT_W-1:0];
        end
      end
      CMD_PLOG: begin
        if (!active_valid) begin
          r.st = ST_NO_PARTNER;
        end else begin
          r.slot = active_slot;
          r.entry = slot_ptr[active_slot];
          slot_ptr[active_slot] = slot_ptr[active_slot] + 1'b1;
        end
      end
      default: begin
        clear_journal();
      end
    endcase
    return r;
  endfunction

  task automatic report_mismatch(string field, int got, int want);
    mismatch_count++;
    if (mismatch_count <= 20) begin
      $display("mismatch on result %0d: %s got %0d, expected %0d at %0t",
               result_count, field, got, want, $realtime);
    end
  endtask

  always @(posedge clk) begin
    journal_result_t want;
    if (!rst && out_valid && out_ready) begin
      if (pending_results.size() == 0) begin
        report_mismatch("unexpected result, queue depth", 1, 0);
      end else begin
        want = pending_results.pop_front();
        if (status !== want.st) report_mismatch("status", status, want.st);
        if (slot_used !== want.slot) report_mismatch("slot_used", slot_used, want.slot);
        if (entry_written !== want.entry)
          report_mismatch("entry_written", entry_written, want.entry);
        if (new_partner !== want.fresh)
          report_mismatch("new_partner", new_partner, want.fresh);
        if (evicted !== want.evict) report_mismatch("evicted", evicted, want.evict);
      end
      result_count++;
    end
  end

  always begin
    @(posedge clk);
    if (!rst && stalls_on && $urandom_range(0, 5) == 0) begin
      out_ready <= 1'b0;
      repeat ($urandom_range(1, 19)) @(posedge clk);
    end
    out_ready <= 1'b1;
  end

  task automatic send_request(cmd_t c, logic [PID_W-1:0] pid, logic [EVENT_W-1:0] ev,
                              logic [STAMP_W-1:0] ts);
    if (gaps_on && $urandom_range(0, 3) == 0) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 19)) @(posedge clk);
    end
    in_valid   <= 1'b1;
    cmd        <= c;
    partner_id <= pid;
    event_code <= ev;
    time_stamp <= ts;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    pending_results.push_back(predict_journal(c, pid));
  endtask

  task automatic wait_for_results();
    in_valid <= 1'b0;
    while (pending_results.size() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  task automatic test_directed();
    gaps_on = 1'b0;
    stalls_on = 1'b0;
    send_request(CMD_LOG, '0, 8'h00, 16'h0000);
    send_request(CMD_LOG, 16'hFFFF, 8'hFF, 16'hFFFF);
    send_request(CMD_PLOG, 16'h0001, 8'hA5, 16'h5A5A);
    send_request(CMD_SELECT, '0, 8'h00, 16'h0000);
    send_request(CMD_SELECT, 16'hFFFF, 8'h01, 16'h0001);
    send_request(CMD_SELECT, 16'h0001, 8'h02, 16'h0002);
    send_request(CMD_SELECT, 16'hFFFF, 8'h03, 16'h0003);
    send_request(CMD_PLOG, 16'h0000, 8'hFF, 16'hFFFF);
    for (int i = 0; i < 6; i++) begin
      send_request(CMD_SELECT, 16'h0100 << i, 8'(i), 16'(i));
    end
    send_request(CMD_SELECT, 16'h1234, 8'h10, 16'h1000);
    send_request(CMD_PLOG, 16'hFFFF, 8'h80, 16'h8000);
    send_request(CMD_SELECT, 16'hFFFF, 8'h11, 16'h1100);
    send_request(CMD_PURGE, 16'hFFFF, 8'hFF, 16'hFFFF);
    send_request(CMD_PLOG, 16'h0001, 8'h12, 16'h1200);
    send_request(CMD_LOG, 16'h0000, 8'h13, 16'h1300);
    send_request(CMD_SELECT, 16'h5A5A, 8'h14, 16'h1400);
  endtask

  task automatic test_slot_wrap(int count);
    gaps_on = 1'b1;
    stalls_on = 1'b1;
    send_request(CMD_SELECT, 16'($urandom_range(1, 65535)), 8'($urandom), 16'($urandom));
    repeat (count) begin
      send_request(CMD_PLOG, 16'($urandom), 8'($urandom), 16'($urandom));
    end
  endtask

  task automatic test_random_traffic(int count, int pool_size, bit idle);
    int pick;
    cmd_t c;
    logic [PID_W-1:0] pid;
    gaps_on = idle;
    stalls_on = idle;
    for (int i = 0; i < pool_size; i++) begin
      id_pool[i] = 16'($urandom_range(1, 65535));
    end
    repeat (count) begin
      pick = $urandom_range(0, 99);
      if (pick < 25) c = CMD_LOG;
      else if (pick < 55) c = CMD_SELECT;
      else if (pick < 97) c = CMD_PLOG;
      else c = CMD_PURGE;
      pick = $urandom_range(0, 99);
      if (c != CMD_SELECT || pick < 10) pid = 16'($urandom);
      else if (pick < 15) pid = '0;
      else pid = id_pool[$urandom_range(0, pool_size - 1)];
      send_request(c, pid, 8'($urandom), 16'($urandom));
    end
  endtask

  initial begin
    clear_journal();
    rst        <= 1'b1;
    in_valid   <= 1'b0;
    out_ready  <= 1'b0;
    cmd        <= CMD_LOG;
    partner_id <= '0;
    event_code <= '0;
    time_stamp <= '0;
    repeat (5) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);
    test_directed();
    test_random_traffic(140, 12, 1'b1);
    test_random_traffic(60, 10, 1'b0);
    wait_for_results();
    test_slot_wrap(40);
    test_random_traffic(100, 3, 1'b1);
    test_random_traffic(60, 12, 1'b0);
    wait_for_results();
    repeat (10) @(posedge clk);
    if (mismatch_count == 0) begin
      $display("[partner_event_journal_top] OK");
    end else begin
      $display("[partner_event_journal_top] ERROR");
    end
    $finish;
  end

  initial begin
    #2000000;
    $display("[partner_event_journal_top] ERROR");
    $finish;
  end

endmodule

// File: filelist.f
rtl/pej_pkg.sv
rtl/pej_ctrl.sv
rtl/pej_datapath.sv
rtl/partner_event_journal_top.sv
bench/partner_event_journal_top_tb.sv
